/* src/fsd_pkg.sv */
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types, constants and helper functions for the speed dispersion block.
// ----------------------------------------------------------------------------
package fsd_pkg;

	localparam int VEL_BITS   = 24;
	localparam int COUNT_BITS = 24;
	localparam int CLS_BITS   = 3;
	localparam int TYPE_BITS  = 3;
	localparam int DISP_BITS  = 32;
	localparam int OUT_CNT_BITS = 24;
	localparam int MEAN_BITS  = 48;
	localparam int Q_BITS     = 64;
	localparam int ADDR_BITS  = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS  = $clog2(QUEUE_DEPTH + 1);

	// Queue limits in the widths of its pointers and fill count.
	localparam logic [QPTR_BITS-1:0] QPTR_LAST  = QPTR_BITS'(QUEUE_DEPTH - 1);
	localparam logic [QCNT_BITS-1:0] QUEUE_FULL = QCNT_BITS'(QUEUE_DEPTH);

	// Register addresses
	localparam logic [ADDR_BITS-1:0] ADDR_HALO_CLASS = 2'd0;

	// Class codes
	localparam logic [CLS_BITS-1:0] CLS_ALL     = 3'd0;
	localparam logic [CLS_BITS-1:0] CLS_DARK    = 3'd1;
	localparam logic [CLS_BITS-1:0] CLS_GAS     = 3'd2;
	localparam logic [CLS_BITS-1:0] CLS_STARS   = 3'd3;
	localparam logic [CLS_BITS-1:0] CLS_VISIBLE = 3'd4;

	// Particle type codes
	localparam logic [TYPE_BITS-1:0] PT_GAS      = 3'd0;
	localparam logic [TYPE_BITS-1:0] PT_HALO     = 3'd1;
	localparam logic [TYPE_BITS-1:0] PT_DISK     = 3'd2;
	localparam logic [TYPE_BITS-1:0] PT_BULGE    = 3'd3;
	localparam logic [TYPE_BITS-1:0] PT_STARS    = 3'd4;
	localparam logic [TYPE_BITS-1:0] PT_BOUNDARY = 3'd5;

	// One classified item as it travels from the front to the back end.
	typedef struct packed {
		logic [VEL_BITS-1:0] mag_x;
		logic [VEL_BITS-1:0] mag_y;
		logic [VEL_BITS-1:0] mag_z;
		logic                counted;
		logic                last;
	} fsd_work_t;

	// Class membership test.
	function automatic logic in_class(input logic [CLS_BITS-1:0] cls,
			input logic [TYPE_BITS-1:0] t);
		logic r;
		begin
			case (cls)
				CLS_ALL:     r = 1'b1;
				CLS_DARK:    r = (t == PT_HALO) || (t == PT_DISK) ||
						(t == PT_BULGE) || (t == PT_BOUNDARY);
				CLS_GAS:     r = (t == PT_GAS);
				CLS_STARS:   r = (t == PT_STARS);
				CLS_VISIBLE: r = (t == PT_GAS) || (t == PT_STARS);
				default:     r = 1'b0;
			endcase
			return r;
		end
	endfunction

	// Magnitude of a signed velocity component.
	function automatic logic [VEL_BITS-1:0] vmag(input logic [VEL_BITS-1:0] v);
		logic [VEL_BITS-1:0] r;
		begin
			r = v[VEL_BITS-1] ? (~v + 1'b1) : v;
			return r;
		end
	endfunction

endpackage

/* src/fsd_if.sv */
// ----------------------------------------------------------------------------
// fsd_in_if / fsd_out_if
// Valid/ready channels for particle items and result items.
// ----------------------------------------------------------------------------
interface fsd_in_if;
	logic                                valid;
	logic                                ready;
	logic [fsd_pkg::VEL_BITS-1:0]        vel_x;
	logic [fsd_pkg::VEL_BITS-1:0]        vel_y;
	logic [fsd_pkg::VEL_BITS-1:0]        vel_z;
	logic [fsd_pkg::TYPE_BITS-1:0]       particle_type;
	logic                                is_last;

	modport source (output valid, vel_x, vel_y, vel_z, particle_type, is_last,
			input ready);
	modport sink (input valid, vel_x, vel_y, vel_z, particle_type, is_last,
			output ready);
endinterface

interface fsd_out_if;
	logic                                valid;
	logic                                ready;
	logic [fsd_pkg::DISP_BITS-1:0]       dispersion;
	logic [fsd_pkg::OUT_CNT_BITS-1:0]    counted;

	modport source (output valid, dispersion, counted, input ready);
	modport sink (input valid, dispersion, counted, output ready);
endinterface

/* src/fsd_front.sv */
// ----------------------------------------------------------------------------
// fsd_front
// Accepts particle items, filters them by class and takes component magnitudes.
// ----------------------------------------------------------------------------
module fsd_front (
	input  logic [fsd_pkg::CLS_BITS-1:0]   halo_class,
	fsd_in_if.sink                         in_ch,
	output logic                           push,
	output fsd_pkg::fsd_work_t             push_data,
	input  logic                           full
);

	// Take an item whenever the queue has room.
	assign in_ch.ready = !full;
	assign push = in_ch.valid && !full;

	// Classify and form magnitudes.
	always_comb begin
		push_data.mag_x   = fsd_pkg::vmag(in_ch.vel_x);
		push_data.mag_y   = fsd_pkg::vmag(in_ch.vel_y);
		push_data.mag_z   = fsd_pkg::vmag(in_ch.vel_z);
		push_data.counted = fsd_pkg::in_class(halo_class, in_ch.particle_type);
		push_data.last    = in_ch.is_last;
	end

endmodule

/* src/fsd_queue.sv */
// ----------------------------------------------------------------------------
// fsd_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module fsd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fsd_pkg::fsd_work_t    push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output fsd_pkg::fsd_work_t    head
);

	fsd_pkg::fsd_work_t mem_q [fsd_pkg::QUEUE_DEPTH];
	logic [fsd_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [fsd_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [fsd_pkg::QCNT_BITS-1:0]   cnt_q;

	assign full = (cnt_q == fsd_pkg::QUEUE_FULL);
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == fsd_pkg::QPTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == fsd_pkg::QPTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + {{(fsd_pkg::QCNT_BITS-1){1'b0}}, push}
					- {{(fsd_pkg::QCNT_BITS-1){1'b0}}, pop};
		end
	end

endmodule

/* src/fsd_back.sv */
// ----------------------------------------------------------------------------
// fsd_back
// Sequencer that runs the speed square root, the Welford update and the final
// dispersion with one shared square root unit and one shared divider.
// ----------------------------------------------------------------------------
module fsd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  not_empty,
	input  fsd_pkg::fsd_work_t    head,
	output logic                  pop,
	fsd_out_if.source             out_ch,
	output logic                  idle
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQRT, ST_DIFF, ST_DIV, ST_MEAN,
		ST_MUL, ST_ACC, ST_ODIV, ST_OSQRT, ST_OUT
	} state_t;

	localparam logic [fsd_pkg::COUNT_BITS-1:0] CMAX = '1;

	state_t                             state_q;
	fsd_pkg::fsd_work_t                 item_q;
	logic [fsd_pkg::MEAN_BITS-1:0]      mean_q;
	logic [fsd_pkg::Q_BITS-1:0]         q_q;
	logic [fsd_pkg::COUNT_BITS-1:0]     cnt_q;
	logic [fsd_pkg::Q_BITS-1:0]         acc_q;     // sum of squares / radicand
	logic [fsd_pkg::Q_BITS-1:0]         rem_q;     // sqrt remainder
	logic [31:0]                        root_q;
	logic [5:0]                         step_q;
	logic [fsd_pkg::MEAN_BITS:0]        dmag_q;    // |d|
	logic                               dneg_q;
	logic [fsd_pkg::MEAN_BITS-1:0]      xs_q;
	logic [fsd_pkg::Q_BITS-1:0]         quo_q;
	logic [fsd_pkg::Q_BITS-1:0]         drem_q;
	logic [fsd_pkg::MEAN_BITS-1:0]      emag_q;
	logic [1:0]                         mph_q;     // product part
	logic [fsd_pkg::Q_BITS+31:0]        prod_q;
	logic                               out_valid_q;
	logic [fsd_pkg::DISP_BITS-1:0]      disp_q;
	logic [fsd_pkg::OUT_CNT_BITS-1:0]   ocnt_q;

	// Shared squaring of one velocity magnitude per cycle.
	logic [fsd_pkg::VEL_BITS-1:0]       sq_m;
	logic [2*fsd_pkg::VEL_BITS-1:0]     sq_p;
	// Shared sqrt step: two bits of radicand per cycle.
	logic [fsd_pkg::Q_BITS-1:0]         sq_rad;
	logic [33:0]                        sq_trial;
	logic [33:0]                        sq_rem;
	logic                               sq_ok;
	// Shared divider step: one quotient bit per cycle.
	logic [fsd_pkg::COUNT_BITS:0]       dv_trial;
	logic                               dv_ok;
	// Multiplier operands, 24 x 48 partial product.
	logic [23:0]                        mul_a;
	logic [71:0]                        mul_p;
	logic [fsd_pkg::Q_BITS:0]           q_sum;

	always_comb begin
		case (state_q)
			ST_SQ1:  sq_m = item_q.mag_x;
			ST_SQ2:  sq_m = item_q.mag_y;
			default: sq_m = item_q.mag_z;
		endcase
		sq_p     = sq_m * sq_m;
		sq_rad   = acc_q;
		sq_rem   = {rem_q[31:0], sq_rad[63:62]};
		sq_trial = {root_q, 2'b01};
		sq_ok    = (sq_rem >= sq_trial);
		dv_trial = {drem_q[fsd_pkg::COUNT_BITS-1:0], quo_q[63]};
		dv_ok    = (dv_trial >= {1'b0, cnt_q});
		mul_a    = mph_q[0] ? dmag_q[47:24] : dmag_q[23:0];
		mul_p    = mul_a * emag_q;
		q_sum    = {1'b0, q_q} + {1'b0, prod_q[95:32]};
	end

	assign pop = (state_q == ST_IDLE) && not_empty;
	assign idle = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.dispersion = disp_q;
	assign out_ch.counted = ocnt_q;

	// Sequencer with its datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mean_q      <= '0;
			q_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output stage reloads the result register itself.
			if (out_valid_q && out_ch.ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (not_empty) begin
						item_q <= head;
						acc_q  <= '0;
						if (head.counted) begin
							state_q <= ST_SQ1;
						end else if (head.last) begin
							state_q <= ST_ODIV;
						end
						if (!head.counted && head.last) begin
							quo_q  <= q_q;
							drem_q <= '0;
							step_q <= '0;
						end
					end
				end
				ST_SQ1: begin
					acc_q   <= 64'(sq_p);
					state_q <= ST_SQ2;
				end
				ST_SQ2: begin
					acc_q   <= acc_q + 64'(sq_p);
					state_q <= ST_SQ3;
				end
				ST_SQ3: begin
					acc_q   <= (acc_q + 64'(sq_p)) << 16;
					rem_q   <= '0;
					root_q  <= '0;
					step_q  <= '0;
					if (cnt_q != CMAX) begin
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					acc_q  <= acc_q << 2;
					rem_q  <= 64'(sq_ok ? (sq_rem - sq_trial) : sq_rem);
					root_q <= {root_q[30:0], sq_ok};
					step_q <= step_q + 1'b1;
					if (step_q == 6'd31) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					xs_q <= {root_q, 16'd0};
					if ({root_q, 16'd0} >= mean_q) begin
						dneg_q <= 1'b0;
						dmag_q <= {1'b0, {root_q, 16'd0} - mean_q};
						quo_q  <= {16'd0, {root_q, 16'd0} - mean_q};
					end else begin
						dneg_q <= 1'b1;
						dmag_q <= {1'b0, mean_q - {root_q, 16'd0}};
						quo_q  <= {16'd0, mean_q - {root_q, 16'd0}};
					end
					drem_q  <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV, ST_ODIV: begin
					// The step counter wraps to zero after the last step.
					quo_q  <= {quo_q[62:0], dv_ok};
					drem_q <= 64'(dv_ok ? (dv_trial - {1'b0, cnt_q}) : dv_trial);
					step_q <= step_q + 1'b1;
					if (step_q == 6'd63) begin
						if (state_q == ST_DIV) begin
							state_q <= ST_MEAN;
						end else begin
							acc_q   <= {quo_q[62:0], dv_ok};
							rem_q   <= '0;
							root_q  <= '0;
							state_q <= ST_OSQRT;
						end
					end
				end
				ST_MEAN: begin
					// The mean moves toward the speed, so |e| = |d| - step.
					if (dneg_q) begin
						mean_q <= mean_q - quo_q[47:0];
					end else begin
						mean_q <= mean_q + quo_q[47:0];
					end
					emag_q  <= dmag_q[47:0] - quo_q[47:0];
					mph_q   <= '0;
					prod_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mph_q[0]) begin
						prod_q  <= prod_q + {mul_p, 24'd0};
						state_q <= ST_ACC;
					end else begin
						prod_q <= {24'd0, mul_p};
					end
					mph_q <= mph_q + 1'b1;
				end
				ST_ACC: begin
					q_q <= q_sum[64] ? '1 : q_sum[63:0];
					if (item_q.last) begin
						quo_q   <= q_sum[64] ? '1 : q_sum[63:0];
						drem_q  <= '0;
						step_q  <= '0;
						state_q <= ST_ODIV;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OSQRT: begin
					acc_q  <= acc_q << 2;
					rem_q  <= 64'(sq_ok ? (sq_rem - sq_trial) : sq_rem);
					root_q <= {root_q[30:0], sq_ok};
					step_q <= step_q + 1'b1;
					if (step_q == 6'd31) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						disp_q  <= (cnt_q == '0) ? '0 : root_q;
						ocnt_q  <= cnt_q;
						mean_q  <= '0;
						q_q     <= '0;
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* src/filtered_speed_dispersion.sv */
// ----------------------------------------------------------------------------
// filtered_speed_dispersion
// Running speed dispersion of a class-filtered particle set.
// ----------------------------------------------------------------------------
// In the back end a counted particle runs a 32-step square root and a
// 64-step divide by the count, one bit per cycle; a skipped one is only
// popped. A last item adds a divide, a square root and the output step.
// The front end accepts up to two items ahead through a two-entry queue.
// arst_n clears the statistics, the class register and all handshake state.
module filtered_speed_dispersion (
	input  logic                            clk,
	input  logic                            arst_n,
	fsd_in_if.sink                          in_ch,
	fsd_out_if.source                       out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fsd_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic [fsd_pkg::CLS_BITS-1:0] halo_class_q;
	logic                         push;
	fsd_pkg::fsd_work_t           push_data;
	logic                         full;
	logic                         pop;
	logic                         not_empty;
	fsd_pkg::fsd_work_t           head;
	logic                         idle;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr == fsd_pkg::ADDR_HALO_CLASS) ? {29'd0, halo_class_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halo_class_q <= '0;
		end else if (psel && penable && pwrite &&
				paddr == fsd_pkg::ADDR_HALO_CLASS) begin
			halo_class_q <= pwdata[fsd_pkg::CLS_BITS-1:0];
		end
	end

	fsd_front u_front (
		.halo_class(halo_class_q), .in_ch(in_ch),
		.push(push), .push_data(push_data), .full(full)
	);

	fsd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.full(full), .pop(pop), .not_empty(not_empty), .head(head)
	);

	fsd_back u_back (
		.clk(clk), .arst_n(arst_n), .not_empty(not_empty), .head(head),
		.pop(pop), .out_ch(out_ch), .idle(idle)
	);

`ifndef ASSERT_OFF
	// The queue never takes an item while it is full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue overflow");
	// The back end only pulls an item that is present.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue underflow");
	// An idle back end holds no pending result.
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> !out_ch.valid) else $error("idle with result pending");
`endif

endmodule

/* bench/fsd_checker.sv */
// ----------------------------------------------------------------------------
// fsd_checker
// Watches the particle, result and register ports of the speed dispersion
// block, predicts each result from its own copy of the statistics and
// compares it, field by field, with what the block delivers.
// ----------------------------------------------------------------------------
module fsd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	fsd_in_if                             in_ch,
	fsd_out_if                            out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [fsd_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output int                            errors,
	output int                            pending
);

	typedef struct packed {
		logic [fsd_pkg::DISP_BITS-1:0]    dispersion;
		logic [fsd_pkg::OUT_CNT_BITS-1:0] counted;
	} disp_result_t;

	localparam logic [63:0] COUNT_MAX = (64'd1 << fsd_pkg::COUNT_BITS) - 64'd1;

	disp_result_t                   expected_results[$];
	logic [fsd_pkg::CLS_BITS-1:0]   class_sel;
	logic [63:0]                    speed_mean;
	logic [63:0]                    dev_sum;
	logic [63:0]                    n_counted;

	// Bitwise integer square root.
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Particle type filter for a class code.
	function automatic logic type_selected(input logic [fsd_pkg::CLS_BITS-1:0] c,
			input logic [fsd_pkg::TYPE_BITS-1:0] t);
		case (c)
			fsd_pkg::CLS_ALL:     return 1'b1;
			fsd_pkg::CLS_DARK:    return t == fsd_pkg::PT_HALO || t == fsd_pkg::PT_DISK ||
					t == fsd_pkg::PT_BULGE || t == fsd_pkg::PT_BOUNDARY;
			fsd_pkg::CLS_GAS:     return t == fsd_pkg::PT_GAS;
			fsd_pkg::CLS_STARS:   return t == fsd_pkg::PT_STARS;
			fsd_pkg::CLS_VISIBLE: return t == fsd_pkg::PT_GAS || t == fsd_pkg::PT_STARS;
			default:              return 1'b0;
		endcase
	endfunction

	function automatic logic [63:0] abs64(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// Welford update for one particle; queues a result on the last one.
	task automatic update_dispersion(input logic [fsd_pkg::VEL_BITS-1:0] vx,
			input logic [fsd_pkg::VEL_BITS-1:0] vy,
			input logic [fsd_pkg::VEL_BITS-1:0] vz,
			input logic [fsd_pkg::TYPE_BITS-1:0] t, input logic last);
		logic [63:0]  ax, ay, az, speed, step, gain, root;
		logic [127:0] prod;
		longint       d, e;
		disp_result_t r;
		if (type_selected(class_sel, t)) begin
			ax = abs64(longint'($signed(vx)));
			ay = abs64(longint'($signed(vy)));
			az = abs64(longint'($signed(vz)));
			speed = int_sqrt((ax * ax + ay * ay + az * az) << 16) << 16;
			if (n_counted < COUNT_MAX)
				n_counted = n_counted + 1;
			d = longint'(speed) - longint'(speed_mean);
			step = abs64(d) / n_counted;
			speed_mean = d >= 0 ? speed_mean + step : speed_mean - step;
			e = longint'(speed) - longint'(speed_mean);
			if ((d >= 0) == (e >= 0) || e == 0) begin
				prod = 128'(abs64(d)) * 128'(abs64(e));
				gain = prod[95:32];
				dev_sum = (64'hFFFF_FFFF_FFFF_FFFF - dev_sum < gain) ?
						64'hFFFF_FFFF_FFFF_FFFF : dev_sum + gain;
			end
		end
		if (last) begin
			root = (n_counted == 0) ? 64'd0 : int_sqrt(dev_sum / n_counted);
			r.dispersion = root[fsd_pkg::DISP_BITS-1:0];
			r.counted = n_counted[fsd_pkg::OUT_CNT_BITS-1:0];
			expected_results = {expected_results, r};
			speed_mean = 0;
			dev_sum = 0;
			n_counted = 0;
		end
	endtask

	// Track the register, accepted particles and accepted results.
	always @(posedge clk or negedge arst_n) begin
		disp_result_t want;
		if (!arst_n) begin
			class_sel = fsd_pkg::CLS_ALL;
			speed_mean = 0;
			dev_sum = 0;
			n_counted = 0;
			errors = 0;
			pending = 0;
			expected_results.delete();
		end else begin
			if (psel && penable && pwrite && pready &&
					paddr == fsd_pkg::ADDR_HALO_CLASS)
				class_sel = pwdata[fsd_pkg::CLS_BITS-1:0];
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result dispersion=%0h counted=%0d",
							$time, out_ch.dispersion, out_ch.counted);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (out_ch.dispersion !== want.dispersion) begin
						$display("%0t: dispersion expected %0h actual %0h",
								$time, want.dispersion, out_ch.dispersion);
						errors++;
					end
					if (out_ch.counted !== want.counted) begin
						$display("%0t: counted expected %0d actual %0d",
								$time, want.counted, out_ch.counted);
						errors++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				update_dispersion(in_ch.vel_x, in_ch.vel_y, in_ch.vel_z,
						in_ch.particle_type, in_ch.is_last);
			pending = expected_results.size();
		end
	end
endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the speed dispersion block: directed extreme particles and
// random particle sets under each class code but 6, with random gaps on both
// channels and one long result stall. The checker judges the results.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES  = 400;
	localparam int VEL_W          = fsd_pkg::VEL_BITS;
	localparam int TYPE_W         = fsd_pkg::TYPE_BITS;

	logic                          clk;
	logic                          arst_n;
	logic                          psel, penable, pwrite;
	logic [fsd_pkg::ADDR_BITS-1:0] paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;
	int                            errors;
	int                            pending;
	int                            particles_sent;
	int                            idle_cycles;

	fsd_in_if  in_ch();
	fsd_out_if out_ch();

	filtered_speed_dispersion u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	fsd_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
	);

	// Clock with a period of two units.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 60)
			return 0;
		if (p < 95)
			return $urandom_range(3, 1);
		return $urandom_range(60, 20);
	endfunction

	// Velocity component: extremes, small values or full range.
	function automatic logic [VEL_W-1:0] pick_vel();
		case ($urandom_range(7))
			0: return {1'b1, {(VEL_W-1){1'b0}}};
			1: return {1'b0, {(VEL_W-1){1'b1}}};
			2, 3: return VEL_W'($urandom_range(2000)) - VEL_W'(1000);
			default: return VEL_W'($urandom);
		endcase
	endfunction

	// Register write: setup cycle, then access cycle.
	task automatic write_reg(input logic [fsd_pkg::ADDR_BITS-1:0] a,
			input logic [31:0] v);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = a;
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Offer one particle and hold it until the block takes it.
	task automatic send_particle(input logic [VEL_W-1:0] vx,
			input logic [VEL_W-1:0] vy, input logic [VEL_W-1:0] vz,
			input logic [TYPE_W-1:0] t, input logic last);
		int g;
		in_ch.vel_x = vx;
		in_ch.vel_y = vy;
		in_ch.vel_z = vz;
		in_ch.particle_type = t;
		in_ch.is_last = last;
		in_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		particles_sent++;
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			in_ch.valid = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	// Let all results drain, then let the block settle before a register write.
	task automatic drain();
		in_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One random set; a few sets are left empty of counted particles.
	task automatic send_random_set();
		int n;
		n = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(6, 1);
		for (int i = 0; i < n; i++)
			send_particle(pick_vel(), pick_vel(), pick_vel(),
					TYPE_W'($urandom_range(7)), i == n - 1);
	endtask

	// Result side: random ready, with one long hold-off once traffic is going.
	initial begin
		int  g;
		bit  held;
		held = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && particles_sent > 150) begin
				held = 1;
				out_ch.ready = 1'b0;
				repeat (3000) @(negedge clk);
			end
			g = gap_len();
			if (g > 0) begin
				out_ch.ready = 1'b0;
				repeat (g - 1) @(negedge clk);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	// Watchdog on cycles in which no item moves.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Main stimulus sequence.
	initial begin
		logic [fsd_pkg::CLS_BITS-1:0] classes[8];
		logic [VEL_W-1:0]             vmax, vmin;
		classes = '{fsd_pkg::CLS_ALL, fsd_pkg::CLS_DARK, fsd_pkg::CLS_GAS,
				fsd_pkg::CLS_STARS, fsd_pkg::CLS_VISIBLE, 3'd5, 3'd7,
				fsd_pkg::CLS_ALL};
		vmax = {1'b0, {(VEL_W-1){1'b1}}};
		vmin = {1'b1, {(VEL_W-1){1'b0}}};
		idle_cycles = 0;
		particles_sent = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.vel_x = '0;
		in_ch.vel_y = '0;
		in_ch.vel_z = '0;
		in_ch.particle_type = '0;
		in_ch.is_last = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, every type, a lone particle, an empty set.
		write_reg(fsd_pkg::ADDR_HALO_CLASS, 32'(fsd_pkg::CLS_ALL));
		send_particle(vmax, vmax, vmax, fsd_pkg::PT_GAS, 1'b0);
		send_particle(vmin, vmin, vmin, fsd_pkg::PT_HALO, 1'b0);
		send_particle('0, '0, '0, fsd_pkg::PT_DISK, 1'b0);
		send_particle(vmin, vmax, '0, fsd_pkg::PT_BULGE, 1'b0);
		send_particle(VEL_W'(1), '0, '1, fsd_pkg::PT_STARS, 1'b0);
		send_particle(vmax, '0, '0, fsd_pkg::PT_BOUNDARY, 1'b0);
		send_particle('0, vmin, '0, 3'd6, 1'b0);
		send_particle('0, '0, vmax, 3'd7, 1'b1);
		send_particle(vmax, vmin, vmax, fsd_pkg::PT_STARS, 1'b1);
		send_particle('0, '0, '0, fsd_pkg::PT_GAS, 1'b1);
		drain();
		write_reg(fsd_pkg::ADDR_HALO_CLASS, 32'(fsd_pkg::CLS_GAS));
		send_particle(vmax, vmax, vmax, fsd_pkg::PT_HALO, 1'b0);
		send_particle(vmin, vmin, vmin, fsd_pkg::PT_STARS, 1'b1);
		send_particle(vmin, '0, vmax, fsd_pkg::PT_GAS, 1'b0);
		send_particle(vmax, vmin, '0, fsd_pkg::PT_GAS, 1'b1);
		drain();
		write_reg(fsd_pkg::ADDR_HALO_CLASS, 32'd7);
		send_particle(vmax, vmax, vmax, fsd_pkg::PT_GAS, 1'b1);
		drain();

		// Random sets under each class setting.
		foreach (classes[k]) begin
			write_reg(fsd_pkg::ADDR_HALO_CLASS, 32'(classes[k]));
			for (int base = particles_sent; particles_sent < base + 60; )
				send_random_set();
			drain();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
